FILE: design/am_lut_waveform_generator_defines.svh
// assertion macros for the lookup-table waveform generator
`ifndef AM_LUT_WAVEFORM_GENERATOR_DEFINES_SVH
`define AM_LUT_WAVEFORM_GENERATOR_DEFINES_SVH

// same-cycle implication, switched off during reset
`define ALWG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off during reset
`define ALWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/alwg_pkg.sv
// shared types, constants and rom tables of the waveform generator
`default_nettype none

package alwg_pkg;

   // transaction kinds on the request channel
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_ADC  = 2'd1;
   localparam logic [1:0] REQ_CMD  = 2'd2;

   // wave selection
   typedef enum logic [1:0] {
      WAVE_SINE   = 2'd0,
      WAVE_TRI    = 2'd1,
      WAVE_SQUARE = 2'd2
   } wave_type;

   // command code boundaries
   localparam logic [7:0] CMD_TRI_BASE    = 8'd11;
   localparam logic [7:0] CMD_SQUARE_BASE = 8'd22;
   localparam logic [7:0] FREQ_MIN        = 8'd1;
   localparam logic [7:0] FREQ_MAX        = 8'd10;
   localparam int         FREQ_W          = 4;

   // tick counter and divider width
   localparam int         DIV_W         = 10;
   localparam logic [DIV_W-1:0] DIVIDER_RESET = 10'd1000;

   // modulation depth
   localparam int          MOD_W      = 13;
   localparam logic [11:0] ADC_OFFSET = 12'd2048;

   // carrier arithmetic
   localparam int SCALED_W      = 17;
   localparam int PRODUCT_W     = 31;
   localparam int SUM_W         = 32;
   localparam int CARRIER_SHIFT = 21;
   localparam logic signed [SUM_W-1:0] CARRIER_BIAS = 32'sd268435456;

   // rom geometry
   localparam int ROM_ENTRIES = 100;
   localparam int ROM_ADDR_W  = 7;
   localparam int ROM_IDX_W   = 10;

   localparam logic [7:0] SINE_ROM [ROM_ENTRIES] = '{
      8'd255, 8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd246, 8'd242, 8'd239, 8'd235,
      8'd230, 8'd225, 8'd220, 8'd214, 8'd208, 8'd202, 8'd195, 8'd188, 8'd181, 8'd174,
      8'd166, 8'd159, 8'd151, 8'd143, 8'd135, 8'd127, 8'd119, 8'd111, 8'd103, 8'd95,
      8'd88,  8'd80,  8'd73,  8'd66,  8'd59,  8'd52,  8'd46,  8'd40,  8'd34,  8'd29,
      8'd24,  8'd19,  8'd15,  8'd12,  8'd8,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0,
      8'd0,   8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd8,   8'd12,  8'd15,  8'd19,
      8'd24,  8'd29,  8'd34,  8'd40,  8'd46,  8'd52,  8'd59,  8'd66,  8'd73,  8'd80,
      8'd88,  8'd95,  8'd103, 8'd111, 8'd119, 8'd127, 8'd135, 8'd143, 8'd151, 8'd159,
      8'd166, 8'd174, 8'd181, 8'd188, 8'd195, 8'd202, 8'd208, 8'd214, 8'd220, 8'd225,
      8'd230, 8'd235, 8'd239, 8'd242, 8'd246, 8'd248, 8'd250, 8'd252, 8'd253, 8'd254
   };

   localparam logic [7:0] TRI_ROM [ROM_ENTRIES] = '{
      8'd0,   8'd5,   8'd10,  8'd15,  8'd20,  8'd25,  8'd30,  8'd35,  8'd40,  8'd45,
      8'd51,  8'd56,  8'd61,  8'd66,  8'd71,  8'd76,  8'd81,  8'd86,  8'd91,  8'd96,
      8'd102, 8'd107, 8'd112, 8'd117, 8'd122, 8'd127, 8'd132, 8'd137, 8'd142, 8'd147,
      8'd153, 8'd158, 8'd163, 8'd168, 8'd173, 8'd178, 8'd183, 8'd188, 8'd193, 8'd198,
      8'd204, 8'd209, 8'd214, 8'd219, 8'd224, 8'd229, 8'd234, 8'd239, 8'd244, 8'd249,
      8'd255, 8'd249, 8'd244, 8'd239, 8'd234, 8'd229, 8'd224, 8'd219, 8'd214, 8'd209,
      8'd204, 8'd198, 8'd193, 8'd188, 8'd183, 8'd178, 8'd173, 8'd168, 8'd163, 8'd158,
      8'd153, 8'd147, 8'd142, 8'd137, 8'd132, 8'd127, 8'd122, 8'd117, 8'd112, 8'd107,
      8'd102, 8'd96,  8'd91,  8'd86,  8'd81,  8'd76,  8'd71,  8'd66,  8'd61,  8'd56,
      8'd51,  8'd45,  8'd40,  8'd35,  8'd30,  8'd25,  8'd20,  8'd15,  8'd10,  8'd5
   };

   // request to the remainder unit
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } rem_req_type;

   // answer from the remainder unit
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] remainder;
   } rem_rsp_type;

   // table level for a wave and index, zero past the end of the table
   function automatic logic [7:0] rom_level(input wave_type wave,
                                            input logic [ROM_IDX_W-1:0] idx);
      logic [7:0] level;
      level = 8'd0;
      if (idx < ROM_IDX_W'(ROM_ENTRIES)) begin
         case (wave)
            WAVE_SINE: level = SINE_ROM[idx[ROM_ADDR_W-1:0]];
            WAVE_TRI:  level = TRI_ROM[idx[ROM_ADDR_W-1:0]];
            default:   level = (idx < ROM_IDX_W'(ROM_ENTRIES / 2)) ? 8'd0 : 8'd255;
         endcase
      end
      return level;
   endfunction

   // step divider for a clamped frequency of one to ten
   function automatic logic [DIV_W-1:0] divider_for_freq(input logic [FREQ_W-1:0] freq);
      logic [DIV_W-1:0] divider;
      unique case (freq)
         4'd1:    divider = 10'd500;
         4'd2:    divider = 10'd250;
         4'd3:    divider = 10'd166;
         4'd4:    divider = 10'd125;
         4'd5:    divider = 10'd100;
         4'd6:    divider = 10'd83;
         4'd7:    divider = 10'd71;
         4'd8:    divider = 10'd62;
         4'd9:    divider = 10'd55;
         default: divider = 10'd50;
      endcase
      return divider;
   endfunction

endpackage

`default_nettype wire

FILE: design/am_lut_waveform_generator.sv
// top level of the amplitude-modulated lookup-table waveform generator
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type, req_adc_sample, req_command_code
//   rsp_      out        rsp_valid/rsp_stall  rsp_carrier_level, rsp_baseband_level
//
// adc sample and command transactions never stall the request side and give no result.
// a tick passes through accept, ten remainder steps (one bit of the tick count each),
// a wait for the remainder to be done and a result load; the multiply runs alongside.
// the result sits in an output register, so the next transaction is taken while it waits.
// a stalled result holds the last step of a tick until the output register is free.
// synchronous reset clears the phase indices, count, waves and depth and loads the reset divider.
`default_nettype none

module am_lut_waveform_generator #(
   parameter int TABLE_LENGTH = 100
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_type,
   input  wire [11:0] req_adc_sample,
   input  wire  [7:0] req_command_code,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_carrier_level,
   output logic [7:0] rsp_baseband_level
);

   localparam int IDX_W = $clog2(TABLE_LENGTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_REM  = 4'b0100,
      ST_OUT  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [IDX_W-1:0]                carrier_idx_ff, carrier_idx_in;
   logic [IDX_W-1:0]                baseband_idx_ff, baseband_idx_in;
   logic [alwg_pkg::DIV_W-1:0]      tick_count_ff, tick_count_in;
   logic [alwg_pkg::DIV_W-1:0]      divider_ff, divider_in;
   alwg_pkg::wave_type              req_wave_ff, req_wave_in;
   alwg_pkg::wave_type              act_wave_ff, act_wave_in;
   logic [alwg_pkg::MOD_W-1:0]      mod_level_ff, mod_level_in;

   logic signed [alwg_pkg::SCALED_W-1:0]  scaled_ff, scaled_in;
   logic [7:0]                            base_lvl_ff, base_lvl_in;
   logic signed [alwg_pkg::PRODUCT_W-1:0] product_ff, product_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] carrier_out_ff, carrier_out_in;
   logic [7:0] baseband_out_ff, baseband_out_in;

   logic req_accept;
   logic out_free;

   alwg_pkg::rem_req_type rem_req;
   alwg_pkg::rem_rsp_type rem_rsp;

   logic [7:0]                       cmd_freq_raw;
   logic [alwg_pkg::FREQ_W-1:0]      cmd_freq;
   alwg_pkg::wave_type               cmd_wave;
   logic [7:0]                       sine_level;
   logic signed [8:0]                sine_centred;
   logic signed [alwg_pkg::SUM_W-1:0] carrier_sum;
   logic [alwg_pkg::DIV_W-1:0]       rem_next;
   logic [alwg_pkg::DIV_W-1:0]       count_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // command decode: wave band and clamped frequency
   always_comb begin
      if (req_command_code < alwg_pkg::CMD_TRI_BASE) begin
         cmd_wave     = alwg_pkg::WAVE_SINE;
         cmd_freq_raw = req_command_code;
      end else if (req_command_code < alwg_pkg::CMD_SQUARE_BASE) begin
         cmd_wave     = alwg_pkg::WAVE_TRI;
         cmd_freq_raw = req_command_code - alwg_pkg::CMD_TRI_BASE;
      end else begin
         cmd_wave     = alwg_pkg::WAVE_SQUARE;
         cmd_freq_raw = req_command_code - alwg_pkg::CMD_SQUARE_BASE;
      end
      if (cmd_freq_raw >= alwg_pkg::FREQ_MAX) begin
         cmd_freq = alwg_pkg::FREQ_MAX[alwg_pkg::FREQ_W-1:0];
      end else if (cmd_freq_raw < alwg_pkg::FREQ_MIN) begin
         cmd_freq = alwg_pkg::FREQ_MIN[alwg_pkg::FREQ_W-1:0];
      end else begin
         cmd_freq = cmd_freq_raw[alwg_pkg::FREQ_W-1:0];
      end
   end

   // rom reads and carrier sample scaled by 255
   assign sine_level   = alwg_pkg::rom_level(alwg_pkg::WAVE_SINE,
                                             alwg_pkg::ROM_IDX_W'(carrier_idx_ff));
   assign sine_centred = $signed({1'b0, sine_level}) - 9'sd128;

   // remainder of the tick count by the divider
   assign rem_req.start    = req_accept && (req_type == alwg_pkg::REQ_TICK);
   assign rem_req.dividend = tick_count_ff;
   assign rem_req.divisor  = divider_ff;

   alwg_rem_unit u_rem_unit (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   // carrier level from the registered product
   assign carrier_sum = alwg_pkg::SUM_W'(product_ff) + alwg_pkg::CARRIER_BIAS;
   assign rem_next    = rem_rsp.remainder + alwg_pkg::DIV_W'(1);
   assign count_next  = tick_count_ff + alwg_pkg::DIV_W'(1);

   // sequencer and state updates
   always_comb begin
      state_in        = state_ff;
      carrier_idx_in  = carrier_idx_ff;
      baseband_idx_in = baseband_idx_ff;
      tick_count_in   = tick_count_ff;
      divider_in      = divider_ff;
      req_wave_in     = req_wave_ff;
      act_wave_in     = act_wave_ff;
      mod_level_in    = mod_level_ff;
      scaled_in       = scaled_ff;
      base_lvl_in     = base_lvl_ff;
      product_in      = product_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      carrier_out_in  = carrier_out_ff;
      baseband_out_in = baseband_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  alwg_pkg::REQ_ADC: begin
                     mod_level_in = alwg_pkg::MOD_W'(req_adc_sample)
                                  + alwg_pkg::MOD_W'(alwg_pkg::ADC_OFFSET);
                  end
                  alwg_pkg::REQ_CMD: begin
                     req_wave_in = cmd_wave;
                     divider_in  = alwg_pkg::divider_for_freq(cmd_freq);
                  end
                  alwg_pkg::REQ_TICK: begin
                     scaled_in   = (alwg_pkg::SCALED_W'(sine_centred) <<< 8)
                                 - alwg_pkg::SCALED_W'(sine_centred);
                     base_lvl_in = alwg_pkg::rom_level(act_wave_ff,
                                      alwg_pkg::ROM_IDX_W'(baseband_idx_ff));
                     state_in    = ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            product_in = $signed({1'b0, mod_level_ff}) * scaled_ff;
            state_in   = ST_REM;
         end
         ST_REM: begin
            if (rem_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               carrier_out_in  = carrier_sum[alwg_pkg::SUM_W-1] ? 8'd0 :
                  carrier_sum[alwg_pkg::CARRIER_SHIFT+7:alwg_pkg::CARRIER_SHIFT];
               baseband_out_in = base_lvl_ff;
               carrier_idx_in  = (carrier_idx_ff == IDX_W'(TABLE_LENGTH - 1)) ? '0
                               : carrier_idx_ff + IDX_W'(1);
               if (rem_rsp.remainder == '0) begin
                  baseband_idx_in = (baseband_idx_ff == IDX_W'(TABLE_LENGTH - 1)) ? '0
                                  : baseband_idx_ff + IDX_W'(1);
               end
               if (count_next == divider_ff) begin
                  act_wave_in = req_wave_ff;
               end
               tick_count_in = (rem_next == divider_ff) ? '0 : rem_next;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         carrier_idx_ff  <= '0;
         baseband_idx_ff <= '0;
         tick_count_ff   <= '0;
         divider_ff      <= alwg_pkg::DIVIDER_RESET;
         req_wave_ff     <= alwg_pkg::WAVE_SINE;
         act_wave_ff     <= alwg_pkg::WAVE_SINE;
         mod_level_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         carrier_idx_ff  <= carrier_idx_in;
         baseband_idx_ff <= baseband_idx_in;
         tick_count_ff   <= tick_count_in;
         divider_ff      <= divider_in;
         req_wave_ff     <= req_wave_in;
         act_wave_ff     <= act_wave_in;
         mod_level_ff    <= mod_level_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      scaled_ff       <= scaled_in;
      base_lvl_ff     <= base_lvl_in;
      product_ff      <= product_in;
      carrier_out_ff  <= carrier_out_in;
      baseband_out_ff <= baseband_out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_carrier_level  = carrier_out_ff;
   assign rsp_baseband_level = baseband_out_ff;

endmodule

`default_nettype wire

FILE: design/alwg_rem_unit.sv
// iterative restoring remainder unit, one quotient bit per cycle
`default_nettype none

module alwg_rem_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  alwg_pkg::rem_req_type rem_req,
   output alwg_pkg::rem_rsp_type rem_rsp
);

   localparam int CNT_W = $clog2(alwg_pkg::DIV_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [alwg_pkg::DIV_W-1:0] shift_ff, shift_in;
   logic [alwg_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [alwg_pkg::DIV_W-1:0] divisor_ff, divisor_in;
   logic [alwg_pkg::DIV_W:0]   trial;
   logic [alwg_pkg::DIV_W:0]   trial_diff;

   // shared compare and subtract
   assign trial      = {rem_ff, shift_ff[alwg_pkg::DIV_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};

   // sequencing of the bit steps
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (rem_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(alwg_pkg::DIV_W);
         shift_in   = rem_req.dividend;
         rem_in     = '0;
         divisor_in = rem_req.divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[alwg_pkg::DIV_W-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, divisor_ff}) ? trial_diff[alwg_pkg::DIV_W-1:0]
                                                  : trial[alwg_pkg::DIV_W-1:0];
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: design/alwg_checker.sv
// port-level checks of the waveform generator and their binding
`default_nettype none
`include "am_lut_waveform_generator_defines.svh"

module alwg_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire [1:0] req_type,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_carrier_level,
   input wire [7:0] rsp_baseband_level
);

   logic req_accept;
   assign req_accept = req_valid && !req_stall;

   // a stalled result holds its levels
   `ALWG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_carrier_level) && $stable(rsp_baseband_level), "stalled result changed")

   // a tick transaction keeps the block busy in the next cycle
   `ALWG_ASSERT_NEXT(a_tick_busy, clock, reset, req_accept && (req_type == alwg_pkg::REQ_TICK), req_stall, "tick did not occupy the block")

   // sample and command transactions do not stall the request side
   `ALWG_ASSERT_NEXT(a_update_quick, clock, reset, req_accept && (req_type != alwg_pkg::REQ_TICK), !req_stall, "update transaction stalled the request side")

   // a new result only appears out of a busy tick
   `ALWG_ASSERT_SAME(a_rsp_from_tick, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without a tick in progress")

endmodule

bind am_lut_waveform_generator alwg_checker u_alwg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_type           (req_type),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_carrier_level  (rsp_carrier_level),
   .rsp_baseband_level (rsp_baseband_level)
);

`default_nettype wire
